### rtl/core/iutu_pkg.sv
// ----------------------------------------------------------------------------
// iutu_pkg
// shared types and constants of the inverted uart transceiver
// ----------------------------------------------------------------------------
package iutu_pkg;

    // command codes of an input word
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_RECV = 2'd2;

    localparam int          TICK_W           = 17;
    localparam int          BYTE_BITS        = 8;
    localparam logic [15:0] BIT_PERIOD_RESET = 16'd304;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_TX      = 4'b0010,
        MODE_RX_WAIT = 4'b0100,
        MODE_RX_DATA = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  tx_data;
        logic [31:0] timeout_ticks;
        logic        line_level;
    } in_word_t;

    typedef struct packed {
        logic       line_out;
        logic       drive_enable;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] rx_data;
        logic       timed_out;
    } out_word_t;

endpackage

### rtl/core/iutu_stream_if.sv
// ----------------------------------------------------------------------------
// iutu_stream_if
// valid/ready channel carrying one word of a given payload type
// ----------------------------------------------------------------------------
interface iutu_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/iutu_engine.sv
// ----------------------------------------------------------------------------
// iutu_engine
// frame state of the transceiver, advanced by one tick per accepted word
// ----------------------------------------------------------------------------
module iutu_engine
    import iutu_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] bit_period,
    input  logic        take,
    input  in_word_t    in_word,
    output out_word_t   result
);

    localparam int BIT_IDX_W = ($clog2(DATA_BITS + 3) > 4) ? $clog2(DATA_BITS + 3) : 4;
    localparam logic [BIT_IDX_W-1:0] LAST_TX_IDX = BIT_IDX_W'(DATA_BITS + 1);
    localparam logic [BIT_IDX_W-1:0] DATA_IDX    = BIT_IDX_W'(DATA_BITS);
    localparam logic [BIT_IDX_W-1:0] BYTE_IDX    = BIT_IDX_W'(BYTE_BITS);
    localparam logic [BIT_IDX_W-1:0] IDX_ONE     = BIT_IDX_W'(1);

    mode_t                mode_reg, mode_next;
    logic [BIT_IDX_W-1:0] idx_reg, idx_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [31:0]          wait_reg, wait_next;
    logic [7:0]           shift_reg, shift_next;

    logic [TICK_W-1:0]    period_ext;
    logic [TICK_W-1:0]    target;
    logic [TICK_W-1:0]    tick_inc;
    logic [BIT_IDX_W-1:0] idx_inc;
    logic [BIT_IDX_W-1:0] tx_pos;
    logic [31:0]          wait_src;
    logic [31:0]          wait_dec;
    logic                 watch;

    assign period_ext = {1'b0, bit_period};
    assign target     = (idx_reg == '0) ? (period_ext + {2'b0, bit_period[15:1]}) : period_ext;
    assign tick_inc   = tick_reg + 1'b1;
    assign idx_inc    = idx_reg + 1'b1;
    assign wait_src   = (mode_reg == MODE_IDLE) ? in_word.timeout_ticks : wait_reg;
    assign wait_dec   = (wait_src != '0) ? (wait_src - 1'b1) : wait_src;

    always_comb
    begin
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        tick_next  = tick_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        watch      = 1'b0;
        result     = '0;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (in_word.command == CMD_SEND)
                begin
                    mode_next  = MODE_TX;
                    shift_next = in_word.tx_data;
                    idx_next   = '0;
                    tick_next  = TICK_W'(1);
                end
                else if (in_word.command == CMD_RECV)
                begin
                    if (in_word.timeout_ticks == '0)
                        result.timed_out = 1'b1;
                    else
                        watch = 1'b1;
                end
            end
            MODE_TX:
            begin
                if (tick_reg >= period_ext)
                begin
                    idx_next  = idx_inc;
                    tick_next = TICK_W'(1);
                    if (idx_inc > LAST_TX_IDX)
                    begin
                        mode_next = MODE_IDLE;
                        idx_next  = '0;
                        tick_next = '0;
                    end
                end
                else
                    tick_next = tick_inc;
            end
            MODE_RX_WAIT:
                watch = 1'b1;
            MODE_RX_DATA:
            begin
                if (tick_inc >= target)
                begin
                    tick_next = '0;
                    if (idx_reg < BYTE_IDX && !in_word.line_level)
                        shift_next[idx_reg[2:0]] = 1'b1;
                    idx_next = idx_inc;
                    if (idx_inc >= DATA_IDX)
                    begin
                        result.byte_valid = 1'b1;
                        result.rx_data    = shift_next;
                        mode_next         = MODE_IDLE;
                        idx_next          = '0;
                    end
                end
                else
                    tick_next = tick_inc;
            end
            default:
                mode_next = MODE_IDLE;
        endcase

        // start-level check while waiting for a frame
        if (watch)
        begin
            if (in_word.line_level)
            begin
                mode_next  = MODE_RX_DATA;
                tick_next  = '0;
                idx_next   = '0;
                shift_next = '0;
                wait_next  = wait_src;
            end
            else
            begin
                wait_next = wait_dec;
                if (wait_dec == '0)
                begin
                    mode_next        = MODE_IDLE;
                    result.timed_out = 1'b1;
                end
                else
                    mode_next = MODE_RX_WAIT;
            end
        end

        // pin view after this tick
        tx_pos = idx_next - IDX_ONE;
        if (mode_next == MODE_TX)
        begin
            result.drive_enable = 1'b1;
            if (idx_next == '0)
                result.line_out = 1'b1;
            else if (idx_next <= DATA_IDX)
                result.line_out = (tx_pos < BYTE_IDX) ? !shift_next[tx_pos[2:0]] : 1'b1;
            else
                result.line_out = 1'b0;
        end
        result.busy_res = (mode_next != MODE_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            idx_reg   <= '0;
            tick_reg  <= '0;
            wait_reg  <= '0;
            shift_reg <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            tick_reg  <= tick_next;
            wait_reg  <= wait_next;
            shift_reg <= shift_next;
        end
    end

endmodule

### rtl/core/iutu_out_stage.sv
// ----------------------------------------------------------------------------
// iutu_out_stage
// result register toward the output channel
// ----------------------------------------------------------------------------
module iutu_out_stage
    import iutu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t word,
    output logic      can_load,
    iutu_stream_if.source out_ch
);

    logic      valid_reg;
    out_word_t word_reg;

    // a new word may enter when the register is empty or when the held one leaves in the same cycle
    assign can_load       = !valid_reg || out_ch.ready;
    assign out_ch.valid   = valid_reg;
    assign out_ch.payload = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= word;
    end

endmodule

### rtl/core/inverted_uart_transceiver_unit.sv
// ----------------------------------------------------------------------------
// inverted_uart_transceiver_unit
// half-duplex 8N1 uart on one shared pin with inverted line polarity
// ----------------------------------------------------------------------------
// Each input word is one clock tick of the serial line: the sampled pin level
// plus an optional command (send tx_data, or wait up to timeout_ticks for a
// start bit and receive a byte). Every accepted word yields exactly one result
// word with the pin drive, busy flag and receive/timeout pulses after that
// tick. The line idles low, the start bit is high and a data 1 is a low level.
// Sampling is mid-bit: 1.5 bit periods after the start edge, then every
// period. One word is taken per clock cycle; the result appears in the output
// register in the next cycle, and the input stalls only while that register
// is full and not taken. bit_period is written through bit_period_we and
// bit_period_wdata and takes effect on the next tick, reset value 304.
// ----------------------------------------------------------------------------
module inverted_uart_transceiver_unit
    import iutu_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        bit_period_we,
    input  logic [15:0] bit_period_wdata,
    iutu_stream_if.sink   in_ch,
    iutu_stream_if.source out_ch
);

    logic [15:0] bit_period_reg;
    logic        take;
    logic        can_load;
    out_word_t   result;

    // config register, ticks per serial bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_period_reg <= BIT_PERIOD_RESET;
        else if (bit_period_we)
            bit_period_reg <= bit_period_wdata;
    end

    // a tick is taken whenever the result register has room
    assign in_ch.ready = can_load;
    assign take        = in_ch.valid && can_load;

    // frame state and next-tick logic
    iutu_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_period (bit_period_reg),
        .take       (take),
        .in_word    (in_ch.payload),
        .result     (result)
    );

    // result register decoupling the output handshake
    iutu_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .word     (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

### test/iutu_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iutu_line_checker
// watches both channels of the transceiver, predicts each result word from
// the accepted input words and compares the two field by field
// ----------------------------------------------------------------------------
module iutu_line_checker
    import iutu_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        period_we,
    input  logic [15:0] period_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_word_t    in_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_word_t   out_word,
    output int          fail_count,
    output int          pending
);

    // mirror of the transceiver state
    mode_t       line_mode;
    logic [3:0]  bit_idx;
    logic [16:0] tick_cnt;
    logic [31:0] wait_cnt;
    logic [7:0]  shreg;
    logic [15:0] period;

    out_word_t   predicted_ticks[$];
    int          mismatches = 0;
    int          queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    // one check of the line for a start level while waiting
    task automatic watch_for_start(input logic level, inout logic flag);
        if (level)
        begin
            line_mode = MODE_RX_DATA;
            tick_cnt  = '0;
            bit_idx   = '0;
            shreg     = '0;
        end
        else
        begin
            if (wait_cnt != 0)
                wait_cnt = wait_cnt - 32'd1;
            if (wait_cnt == 0)
            begin
                line_mode = MODE_IDLE;
                flag      = 1'b1;
            end
            else
                line_mode = MODE_RX_WAIT;
        end
    endtask

    task automatic advance_line(input in_word_t w, output out_word_t r);
        logic [16:0] target;
        logic [3:0]  pos;
        logic        tflag;
        r     = '0;
        tflag = 1'b0;
        case (line_mode)
            MODE_IDLE:
            begin
                if (w.command == CMD_SEND)
                begin
                    line_mode = MODE_TX;
                    shreg     = w.tx_data;
                    bit_idx   = '0;
                    tick_cnt  = 17'd1;
                end
                else if (w.command == CMD_RECV)
                begin
                    if (w.timeout_ticks == 0)
                        tflag = 1'b1;
                    else
                    begin
                        wait_cnt = w.timeout_ticks;
                        watch_for_start(w.line_level, tflag);
                    end
                end
            end
            MODE_TX:
            begin
                if (tick_cnt >= {1'b0, period})
                begin
                    tick_cnt = '0;
                    bit_idx  = bit_idx + 4'd1;
                    if (bit_idx > DATA_BITS + 1)
                    begin
                        line_mode = MODE_IDLE;
                        bit_idx   = '0;
                    end
                end
                if (line_mode == MODE_TX)
                    tick_cnt = tick_cnt + 17'd1;
            end
            MODE_RX_WAIT:
                watch_for_start(w.line_level, tflag);
            default:
            begin
                // first sample lands mid-bit, 1.5 periods after the start edge
                target   = (bit_idx == 0) ? ({1'b0, period} + {2'b0, period[15:1]})
                                          : {1'b0, period};
                tick_cnt = tick_cnt + 17'd1;
                if (tick_cnt >= target)
                begin
                    tick_cnt = '0;
                    if (bit_idx < 8 && !w.line_level)
                        shreg[bit_idx] = 1'b1;
                    bit_idx = bit_idx + 4'd1;
                    if (bit_idx >= DATA_BITS)
                    begin
                        r.byte_valid = 1'b1;
                        r.rx_data    = shreg;
                        line_mode    = MODE_IDLE;
                        bit_idx      = '0;
                    end
                end
            end
        endcase

        if (line_mode == MODE_TX)
        begin
            r.drive_enable = 1'b1;
            pos = bit_idx - 4'd1;
            if (bit_idx == 0)
                r.line_out = 1'b1;
            else if (bit_idx <= DATA_BITS)
                r.line_out = (bit_idx <= 8) ? ~shreg[pos] : 1'b1;
            else
                r.line_out = 1'b0;
        end
        r.busy_res  = (line_mode != MODE_IDLE);
        r.timed_out = tflag;
    endtask

    task automatic compare_field(input string fname, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, exp_v, act_v);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t predicted;
        out_word_t oldest;
        if (!rst_n)
        begin
            line_mode = MODE_IDLE;
            bit_idx   = '0;
            tick_cnt  = '0;
            wait_cnt  = '0;
            shreg     = '0;
            period    = BIT_PERIOD_RESET;
            predicted_ticks.delete();
            queued <= 0;
        end
        else
        begin
            if (period_we)
                period = period_wdata;
            if (in_valid && in_ready)
            begin
                advance_line(in_word, predicted);
                predicted_ticks.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (predicted_ticks.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %p",
                             $time, out_word);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    oldest = predicted_ticks.pop_front();
                    compare_field("line_out", 8'(oldest.line_out),
                                  8'(out_word.line_out));
                    compare_field("drive_enable", 8'(oldest.drive_enable),
                                  8'(out_word.drive_enable));
                    compare_field("busy_res", 8'(oldest.busy_res),
                                  8'(out_word.busy_res));
                    compare_field("byte_valid", 8'(oldest.byte_valid),
                                  8'(out_word.byte_valid));
                    compare_field("rx_data", oldest.rx_data, out_word.rx_data);
                    compare_field("timed_out", 8'(oldest.timed_out),
                                  8'(out_word.timed_out));
                end
            end
            queued <= predicted_ticks.size();
        end
    end

endmodule

### test/inverted_uart_transceiver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverted_uart_transceiver_unit_tb
// drives tick words into the inverted uart transceiver: whole send frames,
// receive frames shaped on the line with mid-bit sample points, timeouts,
// ignored commands and random noise, over several bit periods with random
// stalls on both channels; a checker beside the block predicts every result
// word and counts mismatches, and this top gives the verdict
// ----------------------------------------------------------------------------
module inverted_uart_transceiver_unit_tb;
    import iutu_pkg::*;

    localparam int         DATA_BITS   = 8;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;   // code the block must ignore
    localparam int         CYCLE_LIMIT = 200_000;

    logic        clk;
    logic        rst_n;
    logic        bit_period_we;
    logic [15:0] bit_period_wdata;

    int          period;        // bit period currently programmed, in ticks
    bit          idle_on;       // random gaps and stalls allowed in this stretch
    int          cycles = 0;
    int          mismatches;
    int          pending;       // result words still owed by the block

    iutu_stream_if #(.payload_t(in_word_t))  in_ch ();
    iutu_stream_if #(.payload_t(out_word_t)) out_ch ();

    inverted_uart_transceiver_unit #(
        .DATA_BITS(DATA_BITS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .bit_period_we    (bit_period_we),
        .bit_period_wdata (bit_period_wdata),
        .in_ch            (in_ch),
        .out_ch           (out_ch)
    );

    iutu_line_checker #(
        .DATA_BITS(DATA_BITS)
    ) line_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_we    (bit_period_we),
        .period_wdata (bit_period_wdata),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .in_word      (in_ch.payload),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_word     (out_ch.payload),
        .fail_count   (mismatches),
        .pending      (pending)
    );

    always #10 clk = ~clk;

    // watchdog: a hung handshake or a lost result word ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // word level driving
    // ------------------------------------------------------------------------

    // offer one tick word after a random gap, return once it is taken
    task automatic push_word(input in_word_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic push_tick(input logic [1:0] cmd, input logic lvl,
                             input logic [7:0] txd, input logic [31:0] limit);
        in_word_t w;
        w.command       = cmd;
        w.tx_data       = txd;
        w.timeout_ticks = limit;
        w.line_level    = lvl;
        push_word(w);
    endtask

    // a plain tick; while the block is busy it may carry a stray command,
    // which must be ignored
    task automatic push_filler(input logic lvl, input bit busy_noise);
        logic [1:0] cmd;
        cmd = busy_noise ? 2'($urandom_range(0, 3)) : CMD_NONE;
        push_tick(cmd, lvl, 8'($urandom), $urandom);
    endtask

    // stop offering words and wait until every result word has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // register writes only with the block idle and nothing in flight
    task automatic set_period(input logic [15:0] value);
        drain();
        bit_period_we    <= 1'b1;
        bit_period_wdata <= value;
        @(posedge clk);
        bit_period_we    <= 1'b0;
        period = value;
    endtask

    // ------------------------------------------------------------------------
    // line sequences
    // ------------------------------------------------------------------------

    // send command, then ticks up to and including the tick that ends the frame
    task automatic send_frame(input logic [7:0] data, input bit noisy);
        push_tick(CMD_SEND, 1'($urandom_range(0, 1)), data, $urandom);
        repeat ((DATA_BITS + 2) * period)
            push_filler(1'($urandom_range(0, 1)), noisy);
    endtask

    // receive command with 'lead' low ticks before the start level (the
    // accept tick counts), then a full frame of 'data' on the line; a data 1
    // is a low level, the stop bit is low
    task automatic recv_frame(input logic [31:0] limit, input int lead,
                              input logic [7:0] data, input bit noisy);
        int   first_sample;
        int   finish_at;
        logic lvl;
        bit   sample_tick;
        first_sample = period + period / 2;
        finish_at    = first_sample + (DATA_BITS - 1) * period;
        push_tick(CMD_RECV, lead == 0, 8'($urandom), limit);
        for (int i = 1; i <= lead; i++)
            push_filler(i == lead, noisy);
        // offsets from the start detection tick
        for (int o = 1; o < (DATA_BITS + 2) * period; o++)
        begin
            if (o < period)
                lvl = 1'b1;
            else if (o < (DATA_BITS + 1) * period)
                lvl = ~data[o / period - 1];
            else
                lvl = 1'b0;
            sample_tick = (o >= first_sample) && (o <= finish_at) &&
                          ((o - first_sample) % period == 0);
            // glitches away from the sample points must not matter
            if (noisy && !sample_tick && $urandom_range(0, 7) == 0)
                lvl = ~lvl;
            // past the finish tick the block is idle again: no stray commands
            push_filler(lvl, noisy && (o <= finish_at));
        end
    endtask

    // receive that never sees a start level: the last low tick flags timeout
    task automatic timeout_seq(input int limit);
        push_tick(CMD_RECV, 1'b0, 8'($urandom), limit);
        repeat (limit - 1)
            push_filler(1'b0, 1'b1);
    endtask

    // fully random words, then enough quiet ticks to bring any send or
    // receive to its end; the first high level ends a pending wait
    task automatic noise_burst(input int count);
        repeat (count)
            push_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      8'($urandom), $urandom);
        push_filler(1'b1, 1'b0);
        repeat (11 * period + 2)
            push_filler(1'($urandom_range(0, 1)), 1'b0);
    endtask

    task automatic run_random(input int count);
        int          pick;
        int          lead;
        logic [31:0] limit;
        repeat (count)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 35)
                send_frame(8'($urandom), 1'($urandom_range(0, 1)));
            else if (pick < 70)
            begin
                lead  = $urandom_range(0, 6);
                limit = $urandom_range(0, 1) ? $urandom : lead + 1 + $urandom_range(0, 4);
                if (limit <= lead)
                    limit = lead + 1;
                recv_frame(limit, lead, 8'($urandom), 1'($urandom_range(0, 1)));
            end
            else if (pick < 80)
                timeout_seq($urandom_range(1, 12));
            else if (pick < 85)
                push_tick(CMD_RECV, 1'($urandom_range(0, 1)), 8'($urandom), '0);
            else if (pick < 90)
                push_tick(CMD_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom), $urandom);
            else if (pick < 93)
                repeat ($urandom_range(1, 4))
                    push_filler(1'($urandom_range(0, 1)), 1'b0);
            else
                noise_burst($urandom_range(8, 20));
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall before each word, sometimes none at all
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        bit_period_we    = 1'b0;
        bit_period_wdata = '0;
        in_ch.valid      = 1'b0;
        in_ch.payload    = '0;
        out_ch.ready     = 1'b0;
        period           = BIT_PERIOD_RESET;
        idle_on          = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bit period: the short cases
        push_tick(CMD_RECV, 1'b0, 8'($urandom), '0);     // zero timeout
        push_tick(CMD_UNUSED, 1'b1, 8'hFF, 32'hFFFF_FFFF);
        timeout_seq(1);                                   // expires on accept tick
        timeout_seq(3);

        // shortest usual bit period: data extremes, busy commands, edge timeouts
        set_period(16'd4);
        push_tick(CMD_NONE, 1'b0, 8'h00, 32'h0000_0000);
        send_frame(8'h00, 1'b0);
        send_frame(8'hFF, 1'b1);
        recv_frame(32'd1, 0, 8'h00, 1'b0);                // start on the accept tick
        recv_frame(32'hFFFF_FFFF, 5, 8'hFF, 1'b1);
        recv_frame(32'd4, 3, 8'h5A, 1'b0);                // start on the tick that would otherwise expire
        timeout_seq(2);
        push_tick(CMD_RECV, 1'b1, 8'hFF, '0);             // zero timeout, line high
        push_tick(CMD_UNUSED, 1'b0, 8'h00, '0);

        // random traffic over several periods, odd ones and one-tick bits
        run_random(5);
        set_period(16'd5);
        run_random(2);
        drain();
        run_random(2);
        set_period(16'd1);
        run_random(3);
        set_period(16'd7);
        run_random(1);

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
